@@ rtl/ptls_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptls_pkg
// shared types and constants of the phase table light sequencer
// ----------------------------------------------------------------------------
package ptls_pkg;

	localparam int MAX_PHASES   = 8;
	localparam int MAX_CIRCUITS = 4;
	localparam int TIME_W       = 24;
	localparam int PTIME_W      = TIME_W + 1;
	localparam int TOTAL_W      = TIME_W + 3;
	localparam int PH_W         = 3;
	localparam int CI_W         = 2;
	localparam int CNT_W        = 3;
	localparam int STEP_W       = 16;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_WPH   = 2'd1;
	localparam logic [1:0] CMD_WCI   = 2'd2;
	localparam logic [1:0] CMD_START = 2'd3;

	localparam logic [1:0] LS_BEFORE = 2'd0;
	localparam logic [1:0] LS_GREEN  = 2'd1;
	localparam logic [1:0] LS_AFTER  = 2'd2;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [PH_W-1:0]   ps;
		logic [CI_W-1:0]   cs;
		logic [CNT_W-1:0]  ctot;
		logic [TIME_W-1:0] len;
		logic [TIME_W-1:0] gdly;
		logic [TIME_W-1:0] glen;
		logic [STEP_W-1:0] step;
	} item_t;

	typedef struct packed {
		logic [PH_W-1:0]   phase;
		logic [CI_W-1:0]   circuit;
		logic              green;
		logic              sw;
		logic              ev;
		logic [TIME_W-1:0] elapsed;
		logic              last;
	} rslt_t;

	typedef struct packed {
		logic [3:0]        phase_count;
		logic [TIME_W-1:0] start_offset;
	} cfg_t;

endpackage
`default_nettype wire

@@ rtl/ptls_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptls_fifo
// small first-in first-out queue of flip-flops
// ----------------------------------------------------------------------------
module ptls_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              wr_en,
	input  wire  [WIDTH-1:0] wr_data,
	output logic             full,
	input  wire              rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (do_rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/ptls_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptls_front
// accepts input transactions, packs and clamps them, queues them for the back
// ----------------------------------------------------------------------------
module ptls_front
	import ptls_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	output logic               full,
	input  wire  [1:0]         command,
	input  wire  [PH_W-1:0]    phase_sel,
	input  wire  [CI_W-1:0]    circuit_sel,
	input  wire  [CNT_W-1:0]   circuit_total,
	input  wire  [TIME_W-1:0]  phase_length,
	input  wire  [TIME_W-1:0]  green_delay,
	input  wire  [TIME_W-1:0]  green_length,
	input  wire  [STEP_W-1:0]  time_step,
	output logic               item_vld,
	output item_t              item,
	input  wire                item_pop
);
	item_t in_item;
	logic  q_empty;

	always_comb begin
		in_item.cmd  = command;
		in_item.ps   = phase_sel;
		in_item.cs   = circuit_sel;
		// counts above the circuit limit act as the limit
		in_item.ctot = (circuit_total > CNT_W'(MAX_CIRCUITS)) ? CNT_W'(MAX_CIRCUITS)
			: circuit_total;
		in_item.len  = phase_length;
		in_item.gdly = green_delay;
		in_item.glen = green_length;
		in_item.step = time_step;
	end

	ptls_fifo #(.WIDTH($bits(item_t)), .DEPTH(2)) u_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data(in_item),
		.full   (full),
		.rd_en  (item_pop),
		.rd_data(item),
		.empty  (q_empty)
	);

	assign item_vld = !q_empty;
endmodule
`default_nettype wire

@@ rtl/ptls_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptls_back
// sequencer: holds the tables and light states, runs start and tick
// ----------------------------------------------------------------------------
module ptls_back
	import ptls_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  cfg_t  cfg,
	input  wire   item_vld,
	input  item_t item,
	output logic  item_pop,
	output logic  rq_push,
	output rslt_t rq_data,
	input  wire   rq_full
);
	localparam int NCI = MAX_PHASES * MAX_CIRCUITS;
	localparam int IW  = PH_W + CI_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SUM   = 3'd1;
	localparam logic [2:0] ST_MOD   = 3'd2;
	localparam logic [2:0] ST_WALK  = 3'd3;
	localparam logic [2:0] ST_ADV   = 3'd4;
	localparam logic [2:0] ST_TCIRC = 3'd5;
	localparam logic [2:0] ST_FLUSH = 3'd6;

	logic [TIME_W-1:0]  dur_q [MAX_PHASES];
	logic [CNT_W-1:0]   cnt_q [MAX_PHASES];
	logic [TIME_W-1:0]  dly_q [NCI];
	logic [TIME_W-1:0]  grn_q [NCI];
	logic [1:0]         lst_q [NCI];

	logic [2:0]         state_q;
	logic [PH_W-1:0]    cur_q, p_q;
	logic [PTIME_W-1:0] pt_q;
	logic [TOTAL_W-1:0] tot_q, rem_q;
	logic [4:0]         bit_q;
	logic [CNT_W-1:0]   c_q;
	logic               neg_q, found_q;
	logic [STEP_W-1:0]  step_q;
	logic               pend_v_q;
	rslt_t              pend_q;

	logic [3:0]         n_used;
	logic [IW-1:0]      ci;
	logic [TIME_W-1:0]  cd;
	logic [PTIME_W-1:0] ce;
	logic [1:0]         cst;
	logic [TIME_W-1:0]  wdur;
	logic [CNT_W-1:0]   wcnt, cur_cnt;
	logic               here;
	logic [PTIME_W:0]   psum;
	logic [PTIME_W-1:0] psat;
	logic [TOTAL_W:0]   msh;
	logic               can_emit, em_req, em_green, em_ev, circ_act;
	logic [1:0]         nst;
	logic [TIME_W-1:0]  em_el;
	logic               wr_ph, wr_ci;

	assign n_used  = (cfg.phase_count > 4'(MAX_PHASES)) ? 4'(MAX_PHASES) : cfg.phase_count;
	assign ci      = (state_q == ST_WALK) ? {p_q, c_q[CI_W-1:0]} : {cur_q, c_q[CI_W-1:0]};
	assign cd      = dly_q[ci];
	assign ce      = {1'b0, cd} + {1'b0, grn_q[ci]};
	assign cst     = lst_q[ci];
	assign wdur    = dur_q[p_q];
	assign wcnt    = cnt_q[p_q];
	assign cur_cnt = cnt_q[cur_q];
	assign here    = !neg_q && (rem_q < TOTAL_W'(wdur));
	assign psum    = {1'b0, pt_q} + (PTIME_W + 1)'(step_q);
	assign psat    = psum[PTIME_W] ? '1 : psum[PTIME_W-1:0];
	assign msh     = {rem_q, cfg.start_offset[bit_q]};
	assign can_emit = !pend_v_q || !rq_full;

	assign item_pop = (state_q == ST_IDLE) && item_vld;
	assign wr_ph    = item_pop && (item.cmd == CMD_WPH);
	assign wr_ci    = item_pop && (item.cmd == CMD_WCI);

	// per-circuit decision for start walk and tick walk
	always_comb begin
		em_req   = 1'b0;
		em_green = 1'b0;
		em_ev    = 1'b0;
		em_el    = '0;
		nst      = LS_BEFORE;
		circ_act = 1'b0;
		if (state_q == ST_WALK) begin
			circ_act = (c_q < wcnt);
			em_req   = circ_act;
			if (!here || rem_q < TOTAL_W'(cd)) begin
				nst = LS_BEFORE;
			end else if (rem_q < TOTAL_W'(ce)) begin
				nst      = LS_GREEN;
				em_green = 1'b1;
				em_ev    = 1'b1;
				em_el    = TIME_W'(rem_q - TOTAL_W'(cd));
			end else begin
				nst   = LS_AFTER;
				em_ev = 1'b1;
				em_el = TIME_W'(rem_q - TOTAL_W'(ce));
			end
		end else if (state_q == ST_TCIRC) begin
			circ_act = (c_q < cur_cnt);
			if (cst == LS_BEFORE && pt_q > PTIME_W'(cd) && pt_q < ce) begin
				em_req   = circ_act;
				em_green = 1'b1;
				nst      = LS_GREEN;
			end else if (cst == LS_GREEN && pt_q > ce) begin
				em_req = circ_act;
				nst    = LS_AFTER;
			end
		end
	end

	always_comb begin
		rq_data = pend_q;
		rq_data.last = (state_q == ST_FLUSH);
		rq_push = ((state_q == ST_FLUSH) && pend_v_q && !rq_full)
			|| (em_req && pend_v_q && !rq_full);
	end

	// tables written by the write commands
	always_ff @(posedge clk) begin
		if (wr_ph) begin
			dur_q[item.ps] <= item.len;
			cnt_q[item.ps] <= item.ctot;
		end
		if (wr_ci) begin
			dly_q[{item.ps, item.cs}] <= item.gdly;
			grn_q[{item.ps, item.cs}] <= item.glen;
		end
	end

	always_ff @(posedge clk) begin
		if (em_req && can_emit) begin
			pend_q.phase   <= (state_q == ST_WALK) ? p_q : cur_q;
			pend_q.circuit <= c_q[CI_W-1:0];
			pend_q.green   <= em_green;
			pend_q.sw      <= (state_q == ST_TCIRC);
			pend_q.ev      <= em_ev;
			pend_q.elapsed <= em_el;
			pend_q.last    <= 1'b0;
		end
		if (item_pop) begin
			step_q <= item.step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cur_q    <= '0;
			pt_q     <= '0;
			p_q      <= '0;
			c_q      <= '0;
			tot_q    <= '0;
			rem_q    <= '0;
			bit_q    <= '0;
			neg_q    <= 1'b0;
			found_q  <= 1'b0;
			pend_v_q <= 1'b0;
			for (int i = 0; i < NCI; i++) begin
				lst_q[i] <= LS_BEFORE;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_pop && item.cmd == CMD_START) begin
						tot_q <= '0;
						p_q   <= '0;
						if (n_used == 4'd0) begin
							cur_q   <= '0;
							pt_q    <= '0;
							state_q <= ST_FLUSH;
						end else begin
							state_q <= ST_SUM;
						end
					end else if (item_pop && item.cmd == CMD_TICK
						&& {1'b0, cur_q} < n_used) begin
						state_q <= ST_ADV;
					end
				end
				ST_SUM: begin
					tot_q <= tot_q + TOTAL_W'(wdur);
					p_q   <= p_q + PH_W'(1);
					if ({1'b0, p_q} == n_used - 4'd1) begin
						rem_q   <= '0;
						bit_q   <= 5'(TIME_W - 1);
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					// restoring remainder, one offset bit per cycle
					if (tot_q == '0) begin
						rem_q <= '0;
					end else if (msh >= {1'b0, tot_q}) begin
						rem_q <= TOTAL_W'(msh - {1'b0, tot_q});
					end else begin
						rem_q <= TOTAL_W'(msh);
					end
					bit_q <= bit_q - 5'd1;
					if (bit_q == 5'd0) begin
						p_q     <= '0;
						c_q     <= '0;
						neg_q   <= 1'b0;
						found_q <= 1'b0;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (circ_act) begin
						if (can_emit) begin
							lst_q[ci] <= nst;
							pend_v_q  <= 1'b1;
							c_q       <= c_q + CNT_W'(1);
						end
					end else begin
						// end of phase: settle position and reduce remaining time
						if (here) begin
							cur_q   <= p_q;
							pt_q    <= PTIME_W'(rem_q);
							found_q <= 1'b1;
							neg_q   <= 1'b1;
						end else if (!neg_q) begin
							rem_q <= rem_q - TOTAL_W'(wdur);
						end
						c_q <= '0;
						p_q <= p_q + PH_W'(1);
						if ({1'b0, p_q} == n_used - 4'd1) begin
							if (!found_q && !here) begin
								cur_q <= '0;
								pt_q  <= '0;
							end
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_ADV: begin
					if (psat > {1'b0, dur_q[cur_q]}) begin
						for (int c = 0; c < MAX_CIRCUITS; c++) begin
							if (CNT_W'(c) < cur_cnt) begin
								lst_q[{cur_q, CI_W'(c)}] <= LS_BEFORE;
							end
						end
						pt_q  <= psat - {1'b0, dur_q[cur_q]};
						cur_q <= ({1'b0, cur_q} + 4'd1 == n_used) ? '0 : cur_q + PH_W'(1);
					end else begin
						pt_q <= psat;
					end
					c_q     <= '0;
					state_q <= ST_TCIRC;
				end
				ST_TCIRC: begin
					if (circ_act) begin
						if (!em_req) begin
							c_q <= c_q + CNT_W'(1);
						end else if (can_emit) begin
							lst_q[ci] <= nst;
							pend_v_q  <= 1'b1;
							c_q       <= c_q + CNT_W'(1);
						end
					end else begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (!rq_full) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

@@ rtl/phase_table_light_sequencer_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// phase_table_light_sequencer_core
// sequences a table of light phases and reports circuit lights and switches
//
//  channel   handshake              payload
//  input     push / full            command, selectors, table data, time_step
//  result    empty / pop            out_phase .. last_of_run
//  config    cfg_valid / cfg_ready  cfg_index (0 phase_count, 1 start_offset)
//
// a write is done in the back's idle state; a tick runs advance, a circuit
// pass and flush; a start sums the n phase lengths in use, then takes the
// bit-serial remainder of the offset by the total, walks all phases, flushes
// reset clears the light states, position and queues; tables are undefined
// a full result queue stalls the back, a full item queue raises full
// ----------------------------------------------------------------------------
module phase_table_light_sequencer_core
	import ptls_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	// input transactions
	input  wire                push,
	output logic               full,
	input  wire  [1:0]         command,
	input  wire  [PH_W-1:0]    phase_sel,
	input  wire  [CI_W-1:0]    circuit_sel,
	input  wire  [CNT_W-1:0]   circuit_total,
	input  wire  [TIME_W-1:0]  phase_length,
	input  wire  [TIME_W-1:0]  green_delay,
	input  wire  [TIME_W-1:0]  green_length,
	input  wire  [STEP_W-1:0]  time_step,
	// result transactions
	output logic               empty,
	input  wire                pop,
	output logic [PH_W-1:0]    out_phase,
	output logic [CI_W-1:0]    out_circuit,
	output logic               light_green,
	output logic               is_switch,
	output logic               elapsed_valid,
	output logic [TIME_W-1:0]  elapsed_in_light,
	output logic               last_of_run,
	// configuration writes
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire                cfg_index,
	input  wire  [TIME_W-1:0]  cfg_data
);
	cfg_t  cfg_q;
	item_t item;
	logic  item_vld, item_pop;
	logic  rq_push, rq_full;
	rslt_t rq_data, rq_head;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == 1'b0) begin
				cfg_q.phase_count <= cfg_data[3:0];
			end else begin
				cfg_q.start_offset <= cfg_data;
			end
		end
	end

	// front: accept and pack items
	ptls_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.command      (command),
		.phase_sel    (phase_sel),
		.circuit_sel  (circuit_sel),
		.circuit_total(circuit_total),
		.phase_length (phase_length),
		.green_delay  (green_delay),
		.green_length (green_length),
		.time_step    (time_step),
		.item_vld     (item_vld),
		.item         (item),
		.item_pop     (item_pop)
	);

	// back: sequencer
	ptls_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.item_vld(item_vld),
		.item    (item),
		.item_pop(item_pop),
		.rq_push (rq_push),
		.rq_data (rq_data),
		.rq_full (rq_full)
	);

	// result queue parts the back from the consumer
	ptls_fifo #(.WIDTH($bits(rslt_t)), .DEPTH(4)) u_rq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (rq_push),
		.wr_data(rq_data),
		.full   (rq_full),
		.rd_en  (pop),
		.rd_data(rq_head),
		.empty  (empty)
	);

	assign out_phase        = rq_head.phase;
	assign out_circuit      = rq_head.circuit;
	assign light_green      = rq_head.green;
	assign is_switch        = rq_head.sw;
	assign elapsed_valid    = rq_head.ev;
	assign elapsed_in_light = rq_head.elapsed;
	assign last_of_run      = rq_head.last;
endmodule
`default_nettype wire
